>>> rtl/ace_pkg.sv
// Shared definitions for the accumulator CPU execute core.
// Holds opcodes, status flag codes, serial ALU request codes and the flag function.
// No dependencies.
package ace_pkg;

    // Width of the accumulator and of a data memory word.
    localparam int WORD_W = 16;

    // Instruction codes.
    localparam logic [4:0] OP_LOAD_MEM = 5'd0;
    localparam logic [4:0] OP_LOAD_VAL = 5'd1;
    localparam logic [4:0] OP_STORE    = 5'd2;
    localparam logic [4:0] OP_ADD      = 5'd3;
    localparam logic [4:0] OP_SUB      = 5'd4;
    localparam logic [4:0] OP_MUL      = 5'd5;
    localparam logic [4:0] OP_DIV      = 5'd6;
    localparam logic [4:0] OP_INC      = 5'd7;
    localparam logic [4:0] OP_DEC      = 5'd8;
    localparam logic [4:0] OP_AND      = 5'd9;
    localparam logic [4:0] OP_OR       = 5'd10;
    localparam logic [4:0] OP_NOT      = 5'd11;
    localparam logic [4:0] OP_JMP      = 5'd12;
    localparam logic [4:0] OP_JZ       = 5'd13;
    localparam logic [4:0] OP_JNZ      = 5'd14;
    localparam logic [4:0] OP_JG       = 5'd15;
    localparam logic [4:0] OP_JL       = 5'd16;
    localparam logic [4:0] OP_JGE      = 5'd17;
    localparam logic [4:0] OP_JLE      = 5'd18;
    localparam logic [4:0] OP_HALT     = 5'd19;

    // Status flag codes.
    localparam logic [2:0] FLAG_NONE  = 3'd0;
    localparam logic [2:0] FLAG_ZERO  = 3'd1;
    localparam logic [2:0] FLAG_CARRY = 3'd2;
    localparam logic [2:0] FLAG_OVF   = 3'd4;

    // Serial ALU operation codes.
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_DIV = 2'd3;

    // Request from the execute control to the serial ALU.
    typedef struct packed {
        logic       start;
        logic [1:0] kind;
    } alu_req_t;

    // Status returned by the serial ALU.
    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

    // Status from a result: zero wins, otherwise kind when outside -128..127.
    function automatic logic [2:0] flags_of(input logic [WORD_W-1:0] r,
                                            input logic [2:0] kind);
        logic [2:0] f;
        if (r == '0) begin
            f = FLAG_ZERO;
        end else if (r[WORD_W-1:7] != '0 && r[WORD_W-1:7] != '1) begin
            f = kind;
        end else begin
            f = FLAG_NONE;
        end
        return f;
    endfunction

endpackage

>>> rtl/ace_serial_alu.sv
// Iterative ALU of the execute core: add and subtract one bit per cycle,
// multiply and divide one operand bit per cycle.
// Depends on ace_pkg.
module ace_serial_alu
    import ace_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output alu_rsp_t          rsp,
    output logic [WORD_W-1:0] result
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       kind_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W:0]   rem_reg;
    logic              carry_reg;
    logic              neg_reg;

    logic              last;
    logic              bb;
    logic              sum_bit;
    logic              carry_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] diff;
    logic              borrow;

    assign last = busy_reg && (count_reg == CNT_W'(WORD_W));

    // One bit of the add or subtract, with the subtrahend inverted.
    assign bb         = b_reg[0] ^ (kind_reg == ALU_SUB);
    assign sum_bit    = a_reg[0] ^ bb ^ carry_reg;
    assign carry_next = (a_reg[0] & bb) | (a_reg[0] & carry_reg) | (bb & carry_reg);

    // One restoring divide step on the magnitudes.
    assign shifted = {rem_reg[WORD_W-1:0], a_reg[WORD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, b_reg};
    assign borrow  = diff[WORD_W+1];

    // Control counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (last)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            kind_reg  <= req.kind;
            r_reg     <= '0;
            rem_reg   <= '0;
            carry_reg <= (req.kind == ALU_SUB);
            neg_reg   <= a[WORD_W-1] ^ b[WORD_W-1];
            if (req.kind == ALU_DIV)
            begin
                a_reg <= a[WORD_W-1] ? (~a + WORD_W'(1)) : a;
                b_reg <= b[WORD_W-1] ? (~b + WORD_W'(1)) : b;
            end
            else
            begin
                a_reg <= a;
                b_reg <= b;
            end
        end
        else if (busy_reg && !last)
        begin
            unique case (kind_reg)
                ALU_ADD, ALU_SUB:
                begin
                    r_reg     <= {sum_bit, r_reg[WORD_W-1:1]};
                    carry_reg <= carry_next;
                    a_reg     <= a_reg >> 1;
                    b_reg     <= b_reg >> 1;
                end
                ALU_MUL:
                begin
                    if (b_reg[0])
                    begin
                        r_reg <= r_reg + a_reg;
                    end
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                end
                ALU_DIV:
                begin
                    rem_reg <= borrow ? shifted : diff[WORD_W:0];
                    a_reg   <= {a_reg[WORD_W-2:0], ~borrow};
                end
                default:
                begin
                    r_reg <= r_reg;
                end
            endcase
        end
    end

    // The quotient collects in a_reg and takes its sign at the end.
    assign result = (kind_reg == ALU_DIV)
                  ? (neg_reg ? (~a_reg + WORD_W'(1)) : a_reg)
                  : r_reg;

    assign rsp.busy = busy_reg;
    assign rsp.done = last;

endmodule

>>> rtl/accumulator_cpu_execute_core.sv
// Top level of the accumulator CPU execute core: decode, state, data memory.
// Depends on ace_pkg and ace_serial_alu.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   opcode[4:0], operand[7:0]
// out      output     out_valid / out_stall next_pc[7:0], acc_value[15:0],
//                                           status_flags[2:0], halted
//
// The result reaches the output register from the operand state through write-back for
// loads, stores, logic, jumps, halt and divide by zero, and through the sixteen steps
// of the serial ALU for add, sub, inc, dec, mul and div; a halted core skips the ALU.
// The core returns to idle for the next transaction once the result is loaded.
// Reset clears the accumulator, pc, status and halt mark at once; memory words
// read as zero until stored, through one valid bit per word, so no clearing pass.
// A new input transaction is taken once the previous result sits in the output
// register, even while that register is stalled.
module accumulator_cpu_execute_core
    import ace_pkg::*;
#(
    parameter int DATA_WORDS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         opcode,
    input  logic [7:0]         operand,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         next_pc,
    output logic signed [15:0] acc_value,
    output logic [2:0]         status_flags,
    output logic               halted
);

    localparam int ADDR_W = $clog2(DATA_WORDS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OPER = 2'd1;
    localparam logic [1:0] S_ALU  = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [7:0]        pc_reg, pc_next;
    logic [2:0]        stat_reg, stat_next;
    logic              halt_reg, halt_next;
    logic [2:0]        kind_flag_reg, kind_flag_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_WORDS-1:0] vld_reg;

    logic [4:0]        op_reg;
    logic [7:0]        opd_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_ok_reg;
    logic [7:0]        out_pc_reg;
    logic [WORD_W-1:0] out_acc_reg;
    logic [2:0]        out_stat_reg;
    logic              out_halt_reg;

    logic [WORD_W-1:0] mem [DATA_WORDS];

    logic              accept;
    logic              out_load;
    logic              mem_we;
    logic              rd_in_range;
    logic              wr_in_range;
    logic [WORD_W-1:0] m_val;
    logic [7:0]        step;
    logic [7:0]        target;
    logic              take;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [WORD_W-1:0] alu_b;
    logic [WORD_W-1:0] alu_result;

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign rd_in_range = {1'b0, operand} < 9'(DATA_WORDS);
    assign wr_in_range = {1'b0, opd_reg} < 9'(DATA_WORDS);
    assign m_val       = rd_ok_reg ? rd_data_reg : '0;
    assign step        = pc_reg + 8'd1;
    assign target      = {1'b0, opd_reg[7:1]};

    ace_serial_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (acc_reg),
        .b      (alu_b),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // Branch condition on the signed accumulator.
    always_comb
    begin
        unique case (op_reg) inside
            OP_JMP: take = 1'b1;
            OP_JZ:  take = (acc_reg == '0);
            OP_JNZ: take = (acc_reg != '0);
            OP_JG:  take = !acc_reg[WORD_W-1] && (acc_reg != '0);
            OP_JL:  take = acc_reg[WORD_W-1];
            OP_JGE: take = !acc_reg[WORD_W-1];
            OP_JLE: take = acc_reg[WORD_W-1] || (acc_reg == '0);
            default: take = 1'b0;
        endcase
    end

    // Execute sequencer and next architectural state.
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        pc_next        = pc_reg;
        stat_next      = stat_reg;
        halt_next      = halt_reg;
        kind_flag_next = kind_flag_reg;
        alu_req        = '0;
        alu_b          = m_val;
        mem_we         = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OPER;
                end
            end
            S_OPER:
            begin
                state_next = S_WB;
                if (!halt_reg)
                begin
                    pc_next = step;
                    unique case (op_reg) inside
                        OP_LOAD_MEM:
                        begin
                            acc_next  = m_val;
                            stat_next = flags_of(m_val, FLAG_NONE);
                        end
                        OP_LOAD_VAL:
                        begin
                            acc_next  = {8'd0, opd_reg};
                            stat_next = flags_of({8'd0, opd_reg}, FLAG_NONE);
                        end
                        OP_STORE:
                        begin
                            mem_we = wr_in_range;
                        end
                        OP_ADD, OP_INC:
                        begin
                            alu_req.start  = 1'b1;
                            alu_req.kind   = ALU_ADD;
                            alu_b          = (op_reg == OP_INC) ? WORD_W'(1) : m_val;
                            kind_flag_next = FLAG_CARRY;
                            state_next     = S_ALU;
                        end
                        OP_SUB, OP_DEC:
                        begin
                            alu_req.start  = 1'b1;
                            alu_req.kind   = ALU_SUB;
                            alu_b          = (op_reg == OP_DEC) ? WORD_W'(1) : m_val;
                            kind_flag_next = FLAG_CARRY;
                            state_next     = S_ALU;
                        end
                        OP_MUL:
                        begin
                            alu_req.start  = 1'b1;
                            alu_req.kind   = ALU_MUL;
                            kind_flag_next = FLAG_OVF;
                            state_next     = S_ALU;
                        end
                        OP_DIV:
                        begin
                            if (m_val == '0)
                            begin
                                // Divide by zero keeps the accumulator.
                                stat_next = flags_of(acc_reg, FLAG_NONE);
                            end
                            else
                            begin
                                alu_req.start  = 1'b1;
                                alu_req.kind   = ALU_DIV;
                                kind_flag_next = FLAG_NONE;
                                state_next     = S_ALU;
                            end
                        end
                        OP_AND:
                        begin
                            acc_next  = acc_reg & m_val;
                            stat_next = flags_of(acc_reg & m_val, FLAG_NONE);
                        end
                        OP_OR:
                        begin
                            acc_next  = acc_reg | m_val;
                            stat_next = flags_of(acc_reg | m_val, FLAG_NONE);
                        end
                        OP_NOT:
                        begin
                            acc_next  = ~acc_reg;
                            stat_next = flags_of(~acc_reg, FLAG_NONE);
                        end
                        OP_JMP, OP_JZ, OP_JNZ, OP_JG, OP_JL, OP_JGE, OP_JLE:
                        begin
                            pc_next = take ? target : step;
                        end
                        OP_HALT:
                        begin
                            pc_next   = pc_reg;
                            halt_next = 1'b1;
                        end
                        default:
                        begin
                            pc_next = step;
                        end
                    endcase
                end
            end
            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    acc_next   = alu_result;
                    stat_next  = flags_of(alu_result, kind_flag_reg);
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, cleared when the transaction is taken.
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            pc_reg        <= '0;
            stat_reg      <= '0;
            halt_reg      <= 1'b0;
            kind_flag_reg <= FLAG_NONE;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pc_reg        <= pc_next;
            stat_reg      <= stat_next;
            halt_reg      <= halt_next;
            kind_flag_reg <= kind_flag_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
            begin
                vld_reg[opd_reg[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    // Captured instruction and registered memory read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            opd_reg     <= operand;
            rd_data_reg <= mem[operand[ADDR_W-1:0]];
            rd_ok_reg   <= rd_in_range && vld_reg[operand[ADDR_W-1:0]];
        end
        if (mem_we)
        begin
            mem[opd_reg[ADDR_W-1:0]] <= acc_reg;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pc_reg   <= pc_reg;
            out_acc_reg  <= acc_reg;
            out_stat_reg <= stat_reg;
            out_halt_reg <= halt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = out_pc_reg;
    assign acc_value    = signed'(out_acc_reg);
    assign status_flags = out_stat_reg;
    assign halted       = out_halt_reg;

endmodule

>>> rtl/ace_checker.sv
// Port-level checks for the accumulator CPU execute core, bound to the top level.
// Depends on accumulator_cpu_execute_core for the bind target.
module ace_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         next_pc,
    input logic signed [15:0] acc_value,
    input logic [2:0]         status_flags,
    input logic               halted
);

    logic seen_halt_reg;

    // Remember that a halted result has been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && halted)
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_pc)
            && $stable(acc_value) && $stable(status_flags) && $stable(halted))
        else $error("stalled result changed");

    // The core works on one instruction at a time.
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted while busy");

    // At most one status flag is set in a valid result.
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(status_flags))
        else $error("more than one status flag set");

    // Once halted, every later result reports halted.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_halt_reg |-> halted)
        else $error("core left the halted state");

endmodule

bind accumulator_cpu_execute_core ace_checker u_ace_checker (.*);
